// ----- hdl/fma_pkg.sv -----
// shared types and constants of the flux moment accumulator
`timescale 1ns / 1ps

package fma_pkg;

    // voxel flux width, Q16.8
    localparam int FLUX_W = 24;
    // fraction bits of a centroid
    localparam int FRAC_W = 8;
    // depth of the object queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABS,
        ST_CHECK,
        ST_DIV,
        ST_EMIT
    } fma_state_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } fma_axis_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fma_q_stat_t;

endpackage

// ----- hdl/fma_if.sv -----
// channel interfaces: voxel beats, result beats and the configuration write
`timescale 1ns / 1ps

interface fma_voxel_if #(
    parameter int COORD_BITS = 12
);
    logic                             valid;
    logic                             ready;
    logic        [COORD_BITS-1:0]     pos_x;
    logic        [COORD_BITS-1:0]     pos_y;
    logic        [COORD_BITS-1:0]     pos_z;
    logic signed [fma_pkg::FLUX_W-1:0] flux;
    logic                             member;
    logic                             last;

    modport source (output valid, pos_x, pos_y, pos_z, flux, member, last, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, flux, member, last, output ready);
endinterface

interface fma_result_if #(
    parameter int COORD_BITS = 12,
    parameter int COUNT_BITS = 16
);
    localparam int FSUM_W = fma_pkg::FLUX_W + COUNT_BITS;
    localparam int CEN_W  = COORD_BITS + fma_pkg::FRAC_W;

    logic                             valid;
    logic                             ready;
    logic signed [FSUM_W-1:0]         total_flux;
    logic signed [fma_pkg::FLUX_W-1:0] peak_flux;
    logic        [COORD_BITS-1:0]     peak_x;
    logic        [COORD_BITS-1:0]     peak_y;
    logic        [COORD_BITS-1:0]     peak_z;
    logic        [CEN_W-1:0]          centroid_x;
    logic        [CEN_W-1:0]          centroid_y;
    logic        [CEN_W-1:0]          centroid_z;
    logic                             zero_total;
    logic                             centroid_clipped;

    modport source (
        output valid, total_flux, peak_flux, peak_x, peak_y, peak_z,
               centroid_x, centroid_y, centroid_z, zero_total, centroid_clipped,
        input  ready
    );
    modport sink (
        input  valid, total_flux, peak_flux, peak_x, peak_y, peak_z,
               centroid_x, centroid_y, centroid_z, zero_total, centroid_clipped,
        output ready
    );
endinterface

interface fma_cfg_if;
    logic valid;
    logic ready;
    logic negative_source;

    modport source (output valid, negative_source, input ready);
    modport sink (input valid, negative_source, output ready);
endinterface

// ----- hdl/fma_queue.sv -----
// short object queue between the accumulating front and the dividing back
`timescale 1ns / 1ps

module fma_queue #(
    parameter int DATA_W = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [DATA_W-1:0]    push_data,
    input  logic                 pop,
    output logic [DATA_W-1:0]    head_data,
    output fma_pkg::fma_q_stat_t stat
);

    localparam int PTR_W = (fma_pkg::QUEUE_DEPTH > 1) ? $clog2(fma_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(fma_pkg::QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] mem [fma_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(fma_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign stat.full  = (count_reg == CNT_W'(fma_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ----- hdl/fma_front.sv -----
// front: takes voxel beats, forms products, accumulates moments and tracks the peak
`timescale 1ns / 1ps

module fma_front #(
    parameter int COORD_BITS = 12,
    parameter int COUNT_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    fma_voxel_if.sink                         vox,
    input  logic                              negative_source,
    input  logic                              queue_full,
    output logic                              push,
    output logic signed [fma_pkg::FLUX_W+COUNT_BITS-1:0]            fsum,
    output logic signed [fma_pkg::FLUX_W+COORD_BITS+COUNT_BITS-1:0] wsum_x,
    output logic signed [fma_pkg::FLUX_W+COORD_BITS+COUNT_BITS-1:0] wsum_y,
    output logic signed [fma_pkg::FLUX_W+COORD_BITS+COUNT_BITS-1:0] wsum_z,
    output logic signed [fma_pkg::FLUX_W-1:0]                       peak_value,
    output logic        [COORD_BITS-1:0]                            peak_x,
    output logic        [COORD_BITS-1:0]                            peak_y,
    output logic        [COORD_BITS-1:0]                            peak_z
);

    localparam int FLUX_W = fma_pkg::FLUX_W;
    localparam int FSUM_W = FLUX_W + COUNT_BITS;
    localparam int WSUM_W = FLUX_W + COORD_BITS + COUNT_BITS;
    localparam int PROD_W = FLUX_W + COORD_BITS;

    // product stage
    logic                     s1_valid_reg;
    logic                     s1_member_reg;
    logic                     s1_last_reg;
    logic signed [FLUX_W-1:0] s1_flux_reg;
    logic [COORD_BITS-1:0]    s1_x_reg;
    logic [COORD_BITS-1:0]    s1_y_reg;
    logic [COORD_BITS-1:0]    s1_z_reg;
    logic signed [PROD_W-1:0] s1_prod_x_reg;
    logic signed [PROD_W-1:0] s1_prod_y_reg;
    logic signed [PROD_W-1:0] s1_prod_z_reg;

    // accumulator stage
    logic signed [FSUM_W-1:0] fsum_reg;
    logic signed [WSUM_W-1:0] wsum_x_reg;
    logic signed [WSUM_W-1:0] wsum_y_reg;
    logic signed [WSUM_W-1:0] wsum_z_reg;
    logic signed [FLUX_W-1:0] peak_reg;
    logic [COORD_BITS-1:0]    peak_x_reg;
    logic [COORD_BITS-1:0]    peak_y_reg;
    logic [COORD_BITS-1:0]    peak_z_reg;
    logic                     seen_reg;

    logic signed [PROD_W-1:0] prod_x;
    logic signed [PROD_W-1:0] prod_y;
    logic signed [PROD_W-1:0] prod_z;
    logic signed [FSUM_W-1:0] flux_ext;
    logic                     s1_adv;
    logic                     take;
    logic                     vox_accept;

    // coordinates are non-negative, so a zero top bit keeps them positive
    assign prod_x = PROD_W'($signed({1'b0, vox.pos_x})) * PROD_W'(vox.flux);
    assign prod_y = PROD_W'($signed({1'b0, vox.pos_y})) * PROD_W'(vox.flux);
    assign prod_z = PROD_W'($signed({1'b0, vox.pos_z})) * PROD_W'(vox.flux);

    // the stage moves on unless an end of object meets a full queue
    assign s1_adv     = s1_valid_reg && !(s1_last_reg && queue_full);
    assign vox.ready  = !s1_valid_reg || s1_adv;
    assign vox_accept = vox.valid && vox.ready;
    assign push       = s1_adv && s1_last_reg;
    assign flux_ext   = FSUM_W'(s1_flux_reg);

    always_comb
    begin
        take = !seen_reg ||
               (negative_source ? (s1_flux_reg < peak_reg) : (s1_flux_reg > peak_reg));
        fsum       = fsum_reg;
        wsum_x     = wsum_x_reg;
        wsum_y     = wsum_y_reg;
        wsum_z     = wsum_z_reg;
        peak_value = peak_reg;
        peak_x     = peak_x_reg;
        peak_y     = peak_y_reg;
        peak_z     = peak_z_reg;
        if (s1_member_reg)
        begin
            fsum   = fsum_reg + flux_ext;
            wsum_x = wsum_x_reg + WSUM_W'(s1_prod_x_reg);
            wsum_y = wsum_y_reg + WSUM_W'(s1_prod_y_reg);
            wsum_z = wsum_z_reg + WSUM_W'(s1_prod_z_reg);
            if (take)
            begin
                peak_value = s1_flux_reg;
                peak_x     = s1_x_reg;
                peak_y     = s1_y_reg;
                peak_z     = s1_z_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (vox_accept)
        begin
            s1_member_reg <= vox.member;
            s1_last_reg   <= vox.last;
            s1_flux_reg   <= vox.flux;
            s1_x_reg      <= vox.pos_x;
            s1_y_reg      <= vox.pos_y;
            s1_z_reg      <= vox.pos_z;
            s1_prod_x_reg <= prod_x;
            s1_prod_y_reg <= prod_y;
            s1_prod_z_reg <= prod_z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fsum_reg     <= '0;
            wsum_x_reg   <= '0;
            wsum_y_reg   <= '0;
            wsum_z_reg   <= '0;
            peak_reg     <= '0;
            peak_x_reg   <= '0;
            peak_y_reg   <= '0;
            peak_z_reg   <= '0;
            seen_reg     <= 1'b0;
        end
        else
        begin
            if (vox_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                if (s1_last_reg)
                begin
                    // object handed to the queue, start afresh
                    fsum_reg   <= '0;
                    wsum_x_reg <= '0;
                    wsum_y_reg <= '0;
                    wsum_z_reg <= '0;
                    peak_reg   <= '0;
                    peak_x_reg <= '0;
                    peak_y_reg <= '0;
                    peak_z_reg <= '0;
                    seen_reg   <= 1'b0;
                end
                else
                begin
                    fsum_reg   <= fsum;
                    wsum_x_reg <= wsum_x;
                    wsum_y_reg <= wsum_y;
                    wsum_z_reg <= wsum_z;
                    peak_reg   <= peak_value;
                    peak_x_reg <= peak_x;
                    peak_y_reg <= peak_y;
                    peak_z_reg <= peak_z;
                    seen_reg   <= seen_reg || s1_member_reg;
                end
            end
        end
    end

endmodule

// ----- hdl/fma_back.sv -----
// back: divides the three moments by the total one bit a cycle and holds the result beat
`timescale 1ns / 1ps

module fma_back #(
    parameter int COORD_BITS = 12,
    parameter int COUNT_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              head_valid,
    input  logic signed [fma_pkg::FLUX_W+COUNT_BITS-1:0]            head_fsum,
    input  logic signed [fma_pkg::FLUX_W+COORD_BITS+COUNT_BITS-1:0] head_wsum_x,
    input  logic signed [fma_pkg::FLUX_W+COORD_BITS+COUNT_BITS-1:0] head_wsum_y,
    input  logic signed [fma_pkg::FLUX_W+COORD_BITS+COUNT_BITS-1:0] head_wsum_z,
    input  logic signed [fma_pkg::FLUX_W-1:0]                       head_peak,
    input  logic        [COORD_BITS-1:0]                            head_peak_x,
    input  logic        [COORD_BITS-1:0]                            head_peak_y,
    input  logic        [COORD_BITS-1:0]                            head_peak_z,
    output logic                              pop,
    fma_result_if.source                      res
);

    localparam int FLUX_W = fma_pkg::FLUX_W;
    localparam int FRAC_W = fma_pkg::FRAC_W;
    localparam int FSUM_W = FLUX_W + COUNT_BITS;
    localparam int WSUM_W = FLUX_W + COORD_BITS + COUNT_BITS;
    localparam int CEN_W  = COORD_BITS + FRAC_W;
    localparam int CNT_W  = $clog2(CEN_W);

    fma_pkg::fma_state_t state_reg;
    fma_pkg::fma_state_t state_next;
    fma_pkg::fma_axis_t  axis_reg;

    logic [FSUM_W-1:0] fa_reg;
    logic              fneg_reg;
    logic              zero_reg;
    logic [WSUM_W-1:0] wa_reg;
    logic              wneg_reg;
    logic [FSUM_W-1:0] rem_reg;
    logic [CEN_W-1:0]  dvd_reg;
    logic [CEN_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CEN_W-1:0]  cen_reg [3];
    logic              clip_reg;

    logic              out_valid_reg;
    logic signed [FSUM_W-1:0] out_total_reg;
    logic signed [FLUX_W-1:0] out_peak_reg;
    logic [COORD_BITS-1:0]    out_px_reg;
    logic [COORD_BITS-1:0]    out_py_reg;
    logic [COORD_BITS-1:0]    out_pz_reg;
    logic [CEN_W-1:0]         out_cx_reg;
    logic [CEN_W-1:0]         out_cy_reg;
    logic [CEN_W-1:0]         out_cz_reg;
    logic                     out_zero_reg;
    logic                     out_clip_reg;

    logic signed [WSUM_W-1:0] w_sel;
    logic [FSUM_W:0]          rem_sh;
    logic [FSUM_W:0]          diff;
    logic                     ge;
    logic [CEN_W-1:0]         quo_next;
    logic                     over;
    logic                     axis_done;
    logic [CEN_W-1:0]         cen_val;
    logic                     cen_clip;
    logic                     load_out;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_sh   = {rem_reg, dvd_reg[CEN_W-1]};
    assign diff     = rem_sh - {1'b0, fa_reg};
    assign ge       = !diff[FSUM_W];
    assign quo_next = {quo_reg[CEN_W-2:0], ge};
    // quotient beyond the Q12.8 range exactly when |w| >= |f| * 2^COORD_BITS
    assign over     = (wa_reg >= {fa_reg, {COORD_BITS{1'b0}}});

    always_comb
    begin
        unique case (axis_reg)
            fma_pkg::AXIS_X: w_sel = head_wsum_x;
            fma_pkg::AXIS_Y: w_sel = head_wsum_y;
            fma_pkg::AXIS_Z: w_sel = head_wsum_z;
            default:         w_sel = head_wsum_x;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        axis_done  = 1'b0;
        cen_val    = '0;
        cen_clip   = 1'b0;
        unique case (state_reg)
            fma_pkg::ST_IDLE:
            begin
                if (head_valid)
                begin
                    state_next = fma_pkg::ST_ABS;
                end
            end
            fma_pkg::ST_ABS:
            begin
                state_next = fma_pkg::ST_CHECK;
            end
            fma_pkg::ST_CHECK:
            begin
                if (zero_reg)
                begin
                    axis_done = 1'b1;
                end
                else if (over)
                begin
                    axis_done = 1'b1;
                    cen_clip  = 1'b1;
                    cen_val   = (wneg_reg != fneg_reg) ? '0 : {CEN_W{1'b1}};
                end
                else
                begin
                    state_next = fma_pkg::ST_DIV;
                end
            end
            fma_pkg::ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    axis_done = 1'b1;
                    if (quo_next != '0)
                    begin
                        if (wneg_reg != fneg_reg)
                        begin
                            cen_clip = 1'b1;
                        end
                        else
                        begin
                            cen_val = quo_next;
                        end
                    end
                end
            end
            fma_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    load_out   = 1'b1;
                    pop        = 1'b1;
                    state_next = fma_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fma_pkg::ST_IDLE;
            end
        endcase
        if (axis_done)
        begin
            state_next = (axis_reg == fma_pkg::AXIS_Z) ? fma_pkg::ST_EMIT : fma_pkg::ST_ABS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fma_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg      <= fma_pkg::AXIS_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == fma_pkg::ST_IDLE)
            begin
                axis_reg <= fma_pkg::AXIS_X;
            end
            else if (axis_done)
            begin
                unique case (axis_reg)
                    fma_pkg::AXIS_X: axis_reg <= fma_pkg::AXIS_Y;
                    fma_pkg::AXIS_Y: axis_reg <= fma_pkg::AXIS_Z;
                    default:         axis_reg <= fma_pkg::AXIS_X;
                endcase
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            fma_pkg::ST_IDLE:
            begin
                fa_reg   <= head_fsum[FSUM_W-1] ? FSUM_W'(-head_fsum) : FSUM_W'(head_fsum);
                fneg_reg <= head_fsum[FSUM_W-1];
                zero_reg <= (head_fsum == '0);
                clip_reg <= 1'b0;
            end
            fma_pkg::ST_ABS:
            begin
                wa_reg   <= w_sel[WSUM_W-1] ? WSUM_W'(-w_sel) : WSUM_W'(w_sel);
                wneg_reg <= w_sel[WSUM_W-1];
            end
            fma_pkg::ST_CHECK:
            begin
                rem_reg <= wa_reg[WSUM_W-1:COORD_BITS];
                dvd_reg <= {wa_reg[COORD_BITS-1:0], {FRAC_W{1'b0}}};
                quo_reg <= '0;
                cnt_reg <= CNT_W'(CEN_W - 1);
            end
            fma_pkg::ST_DIV:
            begin
                rem_reg <= ge ? diff[FSUM_W-1:0] : rem_sh[FSUM_W-1:0];
                dvd_reg <= {dvd_reg[CEN_W-2:0], 1'b0};
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            default:
            begin
            end
        endcase
        if (axis_done)
        begin
            cen_reg[axis_reg] <= cen_val;
            clip_reg          <= clip_reg || cen_clip;
        end
        if (load_out)
        begin
            out_total_reg <= head_fsum;
            out_peak_reg  <= head_peak;
            out_px_reg    <= head_peak_x;
            out_py_reg    <= head_peak_y;
            out_pz_reg    <= head_peak_z;
            out_cx_reg    <= cen_reg[fma_pkg::AXIS_X];
            out_cy_reg    <= cen_reg[fma_pkg::AXIS_Y];
            out_cz_reg    <= cen_reg[fma_pkg::AXIS_Z];
            out_zero_reg  <= zero_reg;
            out_clip_reg  <= clip_reg;
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.total_flux       = out_total_reg;
    assign res.peak_flux        = out_peak_reg;
    assign res.peak_x           = out_px_reg;
    assign res.peak_y           = out_py_reg;
    assign res.peak_z           = out_pz_reg;
    assign res.centroid_x       = out_cx_reg;
    assign res.centroid_y       = out_cy_reg;
    assign res.centroid_z       = out_cz_reg;
    assign res.zero_total       = out_zero_reg;
    assign res.centroid_clipped = out_clip_reg;

endmodule

// ----- hdl/flux_moment_accumulator.sv -----
// top level: flux-weighted centroid and peak of one detected object
`timescale 1ns / 1ps
// voxel beats are taken one per cycle unless a full queue holds up the end of an object;
// a beat's products are registered, then added, and an object's sums enter the queue
// while its last beat is in the product stage; the back takes one object at a time, its
// one-bit-a-cycle divider shared across x, y and z; the queue holds two objects
// asynchronous active-low reset clears all accumulators, the queue, the back's
// state machine, the output valid and negative_source; no clearing pass is needed

module flux_moment_accumulator #(
    parameter int COORD_BITS = 12,
    parameter int COUNT_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    fma_voxel_if.sink     vox,
    fma_cfg_if.sink       cfg,
    fma_result_if.source  res
);

    localparam int FLUX_W  = fma_pkg::FLUX_W;
    localparam int FSUM_W  = FLUX_W + COUNT_BITS;
    localparam int WSUM_W  = FLUX_W + COORD_BITS + COUNT_BITS;
    localparam int ENTRY_W = FSUM_W + 3 * WSUM_W + FLUX_W + 3 * COORD_BITS;

    // configuration register, always ready
    logic neg_src_reg;

    // front outputs: the finished sums of an object
    logic                     push;
    logic signed [FSUM_W-1:0] f_fsum;
    logic signed [WSUM_W-1:0] f_wsum_x;
    logic signed [WSUM_W-1:0] f_wsum_y;
    logic signed [WSUM_W-1:0] f_wsum_z;
    logic signed [FLUX_W-1:0] f_peak;
    logic [COORD_BITS-1:0]    f_peak_x;
    logic [COORD_BITS-1:0]    f_peak_y;
    logic [COORD_BITS-1:0]    f_peak_z;

    // queue head seen by the back
    logic [ENTRY_W-1:0]       q_head;
    fma_pkg::fma_q_stat_t     q_stat;
    logic                     pop;
    logic signed [FSUM_W-1:0] h_fsum;
    logic signed [WSUM_W-1:0] h_wsum_x;
    logic signed [WSUM_W-1:0] h_wsum_y;
    logic signed [WSUM_W-1:0] h_wsum_z;
    logic signed [FLUX_W-1:0] h_peak;
    logic [COORD_BITS-1:0]    h_peak_x;
    logic [COORD_BITS-1:0]    h_peak_y;
    logic [COORD_BITS-1:0]    h_peak_z;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_src_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            neg_src_reg <= cfg.negative_source;
        end
    end

    // front: product stage and accumulators, one beat a cycle unless the queue stalls
    fma_front #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .vox             (vox),
        .negative_source (neg_src_reg),
        .queue_full      (q_stat.full),
        .push            (push),
        .fsum            (f_fsum),
        .wsum_x          (f_wsum_x),
        .wsum_y          (f_wsum_y),
        .wsum_z          (f_wsum_z),
        .peak_value      (f_peak),
        .peak_x          (f_peak_x),
        .peak_y          (f_peak_y),
        .peak_z          (f_peak_z)
    );

    // finished objects wait here while the divider works on the one at the head
    fma_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({f_fsum, f_wsum_x, f_wsum_y, f_wsum_z,
                     f_peak, f_peak_x, f_peak_y, f_peak_z}),
        .pop       (pop),
        .head_data (q_head),
        .stat      (q_stat)
    );

    assign {h_fsum, h_wsum_x, h_wsum_y, h_wsum_z,
            h_peak, h_peak_x, h_peak_y, h_peak_z} = q_head;

    // back: centroid division and the output register
    fma_back #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (!q_stat.empty),
        .head_fsum   (h_fsum),
        .head_wsum_x (h_wsum_x),
        .head_wsum_y (h_wsum_y),
        .head_wsum_z (h_wsum_z),
        .head_peak   (h_peak),
        .head_peak_x (h_peak_x),
        .head_peak_y (h_peak_y),
        .head_peak_z (h_peak_z),
        .pop         (pop),
        .res         (res)
    );

    // an object is never handed over into a full queue
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("object pushed into a full queue");

    // the back only releases an object that is there
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("object popped from an empty queue");

    // the voxel side only stalls on back pressure from the queue
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !vox.ready |-> q_stat.full)
        else $error("voxel beat refused with room in the queue");

endmodule
